### design/mcf_pkg.sv
package mcf_pkg;

   localparam int HANDLE_W = 32;
   localparam int ROWS_W = 16;
   localparam int TOTAL_W = 48;
   localparam int USE_W = 4;
   localparam int CNT8_W = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [2:0] ACT_PUSH = 3'd0;
   localparam logic [2:0] ACT_PULL = 3'd1;
   localparam logic [2:0] ACT_OPEN_CONS = 3'd2;
   localparam logic [2:0] ACT_CLOSE_CONS = 3'd3;
   localparam logic [2:0] ACT_OPEN_PROD = 3'd4;
   localparam logic [2:0] ACT_CLOSE_PROD = 3'd5;

   localparam logic [1:0] ST_CHUNK = 2'd0;
   localparam logic [1:0] ST_OK = 2'd1;
   localparam logic [1:0] ST_EOS = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_CONSUMER_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_ROWS = 2'd1;

   localparam logic [USE_W-1:0] USE_MAX = 4'd15;
   localparam logic [CNT8_W-1:0] CNT8_MAX = 8'd255;

   typedef struct packed {
      logic [2:0]          action;
      logic [2:0]          consumer;
      logic [HANDLE_W-1:0] chunk_handle;
      logic [ROWS_W-1:0]   row_count;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [HANDLE_W-1:0] chunk_handle_out;
      logic                can_accept;
      logic                consumer_ready;
   } rsp_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [TOTAL_W-1:0]  offset;
      logic [USE_W-1:0]    use_count;
   } entry_type;

endpackage

### design/mcf_ring.sv
module mcf_ring #(
   parameter int DEPTH = 16,
   parameter int AW = 4
) (
   input  logic                      clock,
   input  logic                      we_entry,
   input  logic                      we_use,
   input  logic [AW-1:0]             wr_addr,
   input  mcf_pkg::entry_type        wr_data,
   input  logic [AW-1:0]             rd_addr,
   output mcf_pkg::entry_type        rd_data
);

   logic [mcf_pkg::HANDLE_W+mcf_pkg::TOTAL_W-1:0] data_mem [DEPTH];
   logic [mcf_pkg::USE_W-1:0]                     use_mem [DEPTH];
   logic [mcf_pkg::HANDLE_W+mcf_pkg::TOTAL_W-1:0] data_rd_ff;
   logic [mcf_pkg::USE_W-1:0]                     use_rd_ff;

   always_ff @(posedge clock) begin
      if (we_entry) begin
         data_mem[wr_addr] <= {wr_data.handle, wr_data.offset};
      end
      data_rd_ff <= data_mem[rd_addr];
   end

   // The use count is written by pushes and by every read-modify-write bump.
   always_ff @(posedge clock) begin
      if (we_use) begin
         use_mem[wr_addr] <= wr_data.use_count;
      end
      use_rd_ff <= use_mem[rd_addr];
   end

   assign rd_data.handle = data_rd_ff[mcf_pkg::HANDLE_W+mcf_pkg::TOTAL_W-1:mcf_pkg::TOTAL_W];
   assign rd_data.offset = data_rd_ff[mcf_pkg::TOTAL_W-1:0];
   assign rd_data.use_count = use_rd_ff;

endmodule

### design/mcf_ctrl.sv
module mcf_ctrl #(
   parameter int MAX_CONSUMERS = 8,
   parameter int DEPTH = 16,
   parameter int SCALE = 16,
   parameter int AW = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  mcf_pkg::req_type            req_data,
   input  logic [3:0]                  consumer_count,
   input  logic [mcf_pkg::ROWS_W-1:0]  chunk_rows,
   input  logic                        out_free,
   output logic                        done,
   output mcf_pkg::rsp_type            result,
   output logic                        we_entry,
   output logic                        we_use,
   output logic [AW-1:0]               wr_addr,
   output mcf_pkg::entry_type          wr_data,
   output logic [AW-1:0]               rd_addr,
   input  mcf_pkg::entry_type          rd_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int CIW = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;
   localparam int FCW = $clog2(MAX_CONSUMERS + 1);
   localparam int OCW = $clog2(MAX_CONSUMERS + 1);
   localparam int TW = mcf_pkg::TOTAL_W;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_PULL_WB, S_CLOSE_RD, S_CLOSE_WR, S_FAST,
      S_FREE_RD, S_FREE_CHK, S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   mcf_pkg::req_type              item_ff, item_in;
   logic [AW-1:0]                 head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]                 count_ff, count_in, walk_ff, walk_in;
   logic [CW-1:0]                 rp_ff [MAX_CONSUMERS];
   logic [CW-1:0]                 rp_in [MAX_CONSUMERS];
   logic [TW-1:0]                 last_ff [MAX_CONSUMERS];
   logic [TW-1:0]                 last_in [MAX_CONSUMERS];
   logic [MAX_CONSUMERS-1:0]      live_ff, live_in;
   logic [mcf_pkg::CNT8_W-1:0]    ocnt_ff [MAX_CONSUMERS];
   logic [mcf_pkg::CNT8_W-1:0]    ocnt_in [MAX_CONSUMERS];
   logic [OCW-1:0]                opc_ff, opc_in;
   logic [mcf_pkg::CNT8_W-1:0]    opp_ff, opp_in;
   logic [TW-1:0]                 total_ff, total_in, fast_ff, fast_in, acc_ff, acc_in;
   logic [FCW-1:0]                fc_ff, fc_in;
   logic [1:0]                    status_ff, status_in;
   logic [mcf_pkg::HANDLE_W-1:0]  hout_ff, hout_in;

   logic [CIW-1:0]                cidx;
   logic                          cvalid;
   logic [CIW-1:0]                fidx;
   logic [AW-1:0]                 pull_idx, walk_idx;
   logic [mcf_pkg::USE_W-1:0]     closed;
   logic [TW-1:0]                 threshold;

   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] offs);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(offs);
      if (s >= (CW+1)'(DEPTH)) begin
         s = s - (CW+1)'(DEPTH);
      end
      return AW'(s);
   endfunction

   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] x);
      return (x == AW'(DEPTH - 1)) ? '0 : x + AW'(1);
   endfunction

   function automatic logic [mcf_pkg::USE_W-1:0] use_bump(
      input logic [mcf_pkg::USE_W-1:0] u);
      return (u == mcf_pkg::USE_MAX) ? u : u + mcf_pkg::USE_W'(1);
   endfunction

   assign cidx = CIW'(item_ff.consumer);
   assign cvalid = ({1'b0, item_ff.consumer} < consumer_count)
                   && (int'(item_ff.consumer) < MAX_CONSUMERS);
   assign fidx = CIW'(fc_ff);
   assign pull_idx = ring_add(head_ff, rp_ff[cidx]);
   assign walk_idx = ring_add(head_ff, walk_ff);
   assign threshold = TW'(chunk_rows) * TW'(SCALE);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      logic [OCW:0] cc_ext;
      logic [OCW:0] diff;
      cc_ext = (OCW+1)'(consumer_count);
      diff = cc_ext - (OCW+1)'(opc_ff);
      if (cc_ext > (OCW+1)'(opc_ff)) begin
         closed = (diff > (OCW+1)'(mcf_pkg::USE_MAX)) ? mcf_pkg::USE_MAX
                                                      : mcf_pkg::USE_W'(diff);
      end else begin
         closed = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      walk_in = walk_ff;
      rp_in = rp_ff;
      last_in = last_ff;
      live_in = live_ff;
      ocnt_in = ocnt_ff;
      opc_in = opc_ff;
      opp_in = opp_ff;
      total_in = total_ff;
      fast_in = fast_ff;
      acc_in = acc_ff;
      fc_in = fc_ff;
      status_in = status_ff;
      hout_in = hout_ff;
      we_entry = 1'b0;
      we_use = 1'b0;
      wr_addr = tail_ff;
      wr_data = '0;
      rd_addr = head_ff;
      done = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               status_in = mcf_pkg::ST_OK;
               hout_in = '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FREE_RD;
            priority case (item_ff.action)
               mcf_pkg::ACT_PUSH: begin
                  if (item_ff.row_count != '0) begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = mcf_pkg::ST_FULL;
                     end else begin
                        we_entry = 1'b1;
                        we_use = 1'b1;
                        wr_addr = tail_ff;
                        wr_data.handle = item_ff.chunk_handle;
                        wr_data.offset = total_ff;
                        wr_data.use_count = closed;
                        tail_in = ring_inc(tail_ff);
                        count_in = count_ff + CW'(1);
                        total_in = total_ff + TW'(item_ff.row_count);
                     end
                  end
               end
               mcf_pkg::ACT_PULL: begin
                  if (cvalid && live_ff[cidx] && (rp_ff[cidx] < count_ff)) begin
                     rd_addr = pull_idx;
                     state_in = S_PULL_WB;
                  end else if (cvalid) begin
                     status_in = (opp_ff == '0) ? mcf_pkg::ST_EOS : mcf_pkg::ST_OK;
                  end
               end
               mcf_pkg::ACT_OPEN_CONS: begin
                  if (cvalid) begin
                     if (ocnt_ff[cidx] == '0) begin
                        opc_in = opc_ff + OCW'(1);
                     end
                     if (ocnt_ff[cidx] != mcf_pkg::CNT8_MAX) begin
                        ocnt_in[cidx] = ocnt_ff[cidx] + mcf_pkg::CNT8_W'(1);
                     end
                  end
               end
               mcf_pkg::ACT_CLOSE_CONS: begin
                  if (cvalid && (ocnt_ff[cidx] != '0)) begin
                     ocnt_in[cidx] = ocnt_ff[cidx] - mcf_pkg::CNT8_W'(1);
                     if (ocnt_ff[cidx] == mcf_pkg::CNT8_W'(1)) begin
                        if (opc_ff != '0) begin
                           opc_in = opc_ff - OCW'(1);
                        end
                        if (live_ff[cidx]) begin
                           walk_in = rp_ff[cidx];
                           state_in = S_CLOSE_RD;
                        end
                     end
                  end
               end
               mcf_pkg::ACT_OPEN_PROD: begin
                  if (opp_ff != mcf_pkg::CNT8_MAX) begin
                     opp_in = opp_ff + mcf_pkg::CNT8_W'(1);
                  end
               end
               mcf_pkg::ACT_CLOSE_PROD: begin
                  if (opp_ff != '0) begin
                     opp_in = opp_ff - mcf_pkg::CNT8_W'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         S_PULL_WB: begin
            we_use = 1'b1;
            wr_addr = pull_idx;
            wr_data.use_count = use_bump(rd_data.use_count);
            rp_in[cidx] = rp_ff[cidx] + CW'(1);
            last_in[cidx] = rd_data.offset;
            if (rd_data.offset > fast_ff) begin
               fast_in = rd_data.offset;
            end
            status_in = mcf_pkg::ST_CHUNK;
            hout_in = rd_data.handle;
            state_in = S_FREE_RD;
         end
         S_CLOSE_RD: begin
            if (walk_ff < count_ff) begin
               rd_addr = walk_idx;
               state_in = S_CLOSE_WR;
            end else begin
               live_in[cidx] = 1'b0;
               rp_in[cidx] = count_ff;
               fc_in = '0;
               acc_in = '0;
               state_in = S_FAST;
            end
         end
         S_CLOSE_WR: begin
            we_use = 1'b1;
            wr_addr = walk_idx;
            wr_data.use_count = use_bump(rd_data.use_count);
            walk_in = walk_ff + CW'(1);
            state_in = S_CLOSE_RD;
         end
         S_FAST: begin
            // One consumer per cycle goes through the running maximum.
            if (int'(fc_ff) < MAX_CONSUMERS) begin
               if ((int'(fc_ff) < int'(consumer_count)) && live_ff[fidx]
                   && (last_ff[fidx] > acc_ff)) begin
                  acc_in = last_ff[fidx];
               end
               fc_in = fc_ff + FCW'(1);
            end else begin
               fast_in = acc_ff;
               state_in = S_FREE_RD;
            end
         end
         S_FREE_RD: begin
            rd_addr = head_ff;
            state_in = (count_ff == '0) ? S_DONE : S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if ({1'b0, rd_data.use_count} >= {1'b0, consumer_count}) begin
               head_in = ring_inc(head_ff);
               count_in = count_ff - CW'(1);
               for (int c = 0; c < MAX_CONSUMERS; c++) begin
                  if (rp_ff[c] != '0) begin
                     rp_in[c] = rp_ff[c] - CW'(1);
                  end
               end
               state_in = S_FREE_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      result.status = status_ff;
      result.chunk_handle_out = hout_ff;
      result.can_accept = ((total_ff - fast_ff) > threshold) ? 1'b0 : 1'b1;
      result.consumer_ready = cvalid
         && ((opp_ff == '0) || (live_ff[cidx] && (rp_ff[cidx] < count_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         live_ff <= '1;
         opc_ff <= '0;
         opp_ff <= '0;
         total_ff <= '0;
         fast_ff <= '0;
         for (int c = 0; c < MAX_CONSUMERS; c++) begin
            rp_ff[c] <= '0;
            last_ff[c] <= '0;
            ocnt_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         live_ff <= live_in;
         opc_ff <= opc_in;
         opp_ff <= opp_in;
         total_ff <= total_in;
         fast_ff <= fast_in;
         rp_ff <= rp_in;
         last_ff <= last_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      walk_ff <= walk_in;
      acc_ff <= acc_in;
      fc_ff <= fc_in;
      status_ff <= status_in;
      hout_ff <= hout_in;
   end

endmodule

### design/multicast_fifo_flow_control.sv
// Shared multicast FIFO with per-consumer read positions and row-based flow control.
// The request channel (req_valid, req_stall, req_data) carries one command per
// transfer: push, pull, open or close a consumer, open or close a producer.
// Every command yields exactly one response transfer on rsp_valid, rsp_stall,
// rsp_data with a status, a returned handle and the can_accept and
// consumer_ready flags as they stand after the command.
// The csr_ port writes consumer_count (index 0) and chunk_rows (index 1); it is
// always ready and is meant to be written while no command is in flight.
// A command passes from acceptance through execution to the response; before the
// response the ring is freed at the head, one entry per read and check, until it
// is empty or the head entry is still in use. A pull adds a ring memory read and
// write-back, and closing a consumer adds a read-modify-write of each unread entry
// it marks plus a rescan of the fastest consumer over all MAX_CONSUMERS slots.
// These walks share the single read port of the ring memory.
// Commands are handled one at a time; req_stall is high while one is in work,
// so the next command can be accepted in the cycle after the response is issued.
// A response waits in the output register while rsp_stall is high, and the
// next command may already be accepted and processed behind it.
// Synchronous reset empties the ring, clears all counts, marks every consumer
// live and restores consumer_count to 2 and chunk_rows to 4096.
module multicast_fifo_flow_control #(
   parameter int MAX_CONSUMERS = 8,
   parameter int DEPTH = 16,
   parameter int SCALE = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mcf_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mcf_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mcf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mcf_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int AW = $clog2(DEPTH);

   logic [3:0]                     ccount_ff, ccount_in;
   logic [mcf_pkg::ROWS_W-1:0]     crows_ff, crows_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   mcf_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   logic                           out_free;
   logic                           done;
   mcf_pkg::rsp_type               result;
   logic                           we_entry, we_use;
   logic [AW-1:0]                  wr_addr, rd_addr;
   mcf_pkg::entry_type             wr_data, rd_data;

   assign csr_ready = 1'b1;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      logic [3:0] v;
      ccount_in = ccount_ff;
      crows_in = crows_ff;
      v = csr_data[3:0];
      if (csr_valid) begin
         if (csr_index == mcf_pkg::CSR_CONSUMER_COUNT) begin
            if (v == 4'd0) begin
               v = 4'd1;
            end
            if (int'(v) > MAX_CONSUMERS) begin
               v = 4'(MAX_CONSUMERS);
            end
            ccount_in = v;
         end else if (csr_index == mcf_pkg::CSR_CHUNK_ROWS) begin
            crows_in = csr_data;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ccount_ff <= 4'd2;
         crows_ff <= 16'd4096;
         rsp_valid_ff <= 1'b0;
      end else begin
         ccount_ff <= ccount_in;
         crows_ff <= crows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   mcf_ctrl #(
      .MAX_CONSUMERS(MAX_CONSUMERS),
      .DEPTH(DEPTH),
      .SCALE(SCALE),
      .AW(AW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .consumer_count(ccount_ff),
      .chunk_rows(crows_ff),
      .out_free(out_free),
      .done(done),
      .result(result),
      .we_entry(we_entry),
      .we_use(we_use),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   mcf_ring #(
      .DEPTH(DEPTH),
      .AW(AW)
   ) u_ring (
      .clock(clock),
      .we_entry(we_entry),
      .we_use(we_use),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int NCONS = 8;
   localparam int RING = 16;
   localparam int THRESH_SCALE = 16;
   localparam int RANDOM_ITEMS = 1300;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   mcf_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   mcf_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [mcf_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mcf_pkg::CSR_DATA_W-1:0] csr_data;

   multicast_fifo_flow_control dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Shadow copy of the ring state.
   logic [3:0]         m_cons_count;
   logic [15:0]        m_chunk_rows;
   logic [31:0]        m_handle [RING];
   logic [47:0]        m_offset [RING];
   logic [3:0]         m_use [RING];
   int unsigned        m_head, m_tail, m_count;
   int unsigned        m_rdpos [NCONS];
   logic [47:0]        m_last [NCONS];
   bit                 m_live [NCONS];
   int unsigned        m_open_cnt [NCONS];
   int unsigned        m_open_cons, m_open_prod;
   logic [47:0]        m_total, m_fastest;

   mcf_pkg::rsp_type expected_rsps[$];
   int errors = 0;
   int n_rsp = 0, n_chunks = 0, n_full = 0, n_eos = 0;
   bit random_idle = 1'b1;
   bit hold_rsp = 1'b0;

   function automatic void model_reset();
      m_cons_count = 4'd2;
      m_chunk_rows = 16'd4096;
      m_head = 0; m_tail = 0; m_count = 0;
      for (int c = 0; c < NCONS; c++) begin
         m_rdpos[c] = 0; m_last[c] = '0; m_live[c] = 1'b1; m_open_cnt[c] = 0;
      end
      m_open_cons = 0; m_open_prod = 0; m_total = '0; m_fastest = '0;
   endfunction

   function automatic void model_csr(logic [mcf_pkg::CSR_IDX_W-1:0] idx, logic [15:0] val);
      logic [3:0] v;
      if (idx == mcf_pkg::CSR_CONSUMER_COUNT) begin
         v = val[3:0];
         if (v == 0) v = 1;
         if (v > NCONS) v = NCONS;
         m_cons_count = v;
      end else if (idx == mcf_pkg::CSR_CHUNK_ROWS) begin
         m_chunk_rows = val;
      end
   endfunction

   function automatic void bump_use(int unsigned idx);
      if (m_use[idx] < mcf_pkg::USE_MAX) m_use[idx]++;
   endfunction

   function automatic mcf_pkg::rsp_type predict_fifo_step(mcf_pkg::req_type r);
      mcf_pkg::rsp_type o;
      int unsigned c, idx, closed;
      bit ok;
      logic [47:0] diff;
      c = r.consumer;
      ok = (c < m_cons_count);
      o.status = mcf_pkg::ST_OK;
      o.chunk_handle_out = '0;
      case (r.action)
         mcf_pkg::ACT_PUSH: begin
            if (r.row_count != 0) begin
               if (m_count >= RING) begin
                  o.status = mcf_pkg::ST_FULL;
               end else begin
                  closed = (m_cons_count > m_open_cons) ? m_cons_count - m_open_cons : 0;
                  m_handle[m_tail] = r.chunk_handle;
                  m_offset[m_tail] = m_total;
                  m_use[m_tail] = (closed > 15) ? 4'd15 : closed[3:0];
                  m_tail = (m_tail + 1) % RING;
                  m_count++;
                  m_total = m_total + 48'(r.row_count);
               end
            end
         end
         mcf_pkg::ACT_PULL: begin
            if (ok && m_live[c] && m_rdpos[c] < m_count) begin
               idx = (m_head + m_rdpos[c]) % RING;
               m_rdpos[c]++;
               bump_use(idx);
               m_last[c] = m_offset[idx];
               if (m_offset[idx] > m_fastest) m_fastest = m_offset[idx];
               o.status = mcf_pkg::ST_CHUNK;
               o.chunk_handle_out = m_handle[idx];
            end else if (ok) begin
               o.status = (m_open_prod == 0) ? mcf_pkg::ST_EOS : mcf_pkg::ST_OK;
            end
         end
         mcf_pkg::ACT_OPEN_CONS: begin
            if (ok) begin
               if (m_open_cnt[c] == 0) m_open_cons++;
               if (m_open_cnt[c] < 255) m_open_cnt[c]++;
            end
         end
         mcf_pkg::ACT_CLOSE_CONS: begin
            if (ok && m_open_cnt[c] > 0) begin
               m_open_cnt[c]--;
               if (m_open_cnt[c] == 0) begin
                  if (m_open_cons > 0) m_open_cons--;
                  if (m_live[c]) begin
                     for (int unsigned k = m_rdpos[c]; k < m_count; k++)
                        bump_use((m_head + k) % RING);
                     m_live[c] = 1'b0;
                     m_rdpos[c] = m_count;
                     m_fastest = '0;
                     for (int j = 0; j < m_cons_count; j++)
                        if (m_live[j] && m_last[j] > m_fastest) m_fastest = m_last[j];
                  end
               end
            end
         end
         mcf_pkg::ACT_OPEN_PROD: if (m_open_prod < 255) m_open_prod++;
         mcf_pkg::ACT_CLOSE_PROD: if (m_open_prod > 0) m_open_prod--;
         default: ;
      endcase
      while (m_count > 0 && m_use[m_head] >= m_cons_count) begin
         m_head = (m_head + 1) % RING;
         m_count--;
         for (int j = 0; j < NCONS; j++) if (m_rdpos[j] > 0) m_rdpos[j]--;
      end
      diff = m_total - m_fastest;
      o.can_accept = (diff > 48'(m_chunk_rows) * THRESH_SCALE) ? 1'b0 : 1'b1;
      o.consumer_ready = (ok && (m_open_prod == 0 ||
                         (m_live[c] && m_rdpos[c] < m_count))) ? 1'b1 : 1'b0;
      return o;
   endfunction

   task automatic send_item(mcf_pkg::req_type r);
      do @(negedge clock); while (random_idle && $urandom_range(99) < 37);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsps.push_back(predict_fifo_step(r));
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send_directed(mcf_pkg::req_type r, logic [1:0] st, logic [31:0] h);
      mcf_pkg::rsp_type e;
      send_item(r);
      e = expected_rsps[$];
      if (e.status !== st || e.chunk_handle_out !== h) begin
         $error("directed row status: expected %0d/%h, predictor %0d/%h",
                st, h, e.status, e.chunk_handle_out);
         errors++;
      end
   endtask

   task automatic drain_and_write(logic [mcf_pkg::CSR_IDX_W-1:0] idx, logic [15:0] val);
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_csr(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic mcf_pkg::req_type mk(logic [2:0] a, logic [2:0] c, logic [31:0] h,
                                           logic [15:0] n);
      mcf_pkg::req_type r;
      r.action = a; r.consumer = c; r.chunk_handle = h; r.row_count = n;
      return r;
   endfunction

   function automatic mcf_pkg::req_type random_item(int mode);
      mcf_pkg::req_type r;
      int p;
      r.chunk_handle = $urandom();
      r.row_count = ($urandom_range(9) == 0) ? 16'($urandom()) :
                    ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 600));
      r.consumer = (mode == 0) ? 3'($urandom_range(m_cons_count - 1)) : 3'($urandom());
      p = $urandom_range(99);
      if (p < 40) r.action = mcf_pkg::ACT_PUSH;
      else if (p < 80) r.action = mcf_pkg::ACT_PULL;
      else if (p < 86) r.action = mcf_pkg::ACT_OPEN_CONS;
      else if (p < 91) r.action = mcf_pkg::ACT_CLOSE_CONS;
      else if (p < 95) r.action = mcf_pkg::ACT_OPEN_PROD;
      else if (p < 98) r.action = mcf_pkg::ACT_CLOSE_PROD;
      else r.action = 3'($urandom_range(6, 7));
      return r;
   endfunction

   // Response side: random stalls, plus a long hold when asked.
   initial begin
      rsp_stall = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_rsp) rsp_stall <= 1'b1;
         else rsp_stall <= random_idle ? ($urandom_range(99) < 37) : 1'b0;
      end
   end

   always @(posedge clock) begin
      mcf_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_rsp++;
         if (expected_rsps.size() == 0) begin
            $error("response transfer with none expected: %p", rsp_data);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.chunk_handle_out !== e.chunk_handle_out) begin
               $error("chunk_handle_out: expected %h, actual %h",
                      e.chunk_handle_out, rsp_data.chunk_handle_out);
               errors++;
            end
            if (rsp_data.can_accept !== e.can_accept) begin
               $error("can_accept: expected %0b, actual %0b", e.can_accept,
                      rsp_data.can_accept);
               errors++;
            end
            if (rsp_data.consumer_ready !== e.consumer_ready) begin
               $error("consumer_ready: expected %0b, actual %0b", e.consumer_ready,
                      rsp_data.consumer_ready);
               errors++;
            end
            if (e.status == mcf_pkg::ST_CHUNK) n_chunks++;
            if (e.status == mcf_pkg::ST_FULL) n_full++;
            if (e.status == mcf_pkg::ST_EOS) n_eos++;
         end
      end
   end

   initial begin
      #50ms;
      $display("*** FAILED ***");
      $finish;
   end

   typedef struct {
      mcf_pkg::req_type item;
      bit       known;
      logic [1:0]  st;
      logic [31:0] h;
   } directed_row;

   initial begin
      directed_row rows[$];
      int unsigned cc;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      model_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows under reset configuration (two consumers).
      rows.push_back('{mk(mcf_pkg::ACT_PULL, 3'd0, '0, '0), 1, mcf_pkg::ST_EOS, '0});
      rows.push_back('{mk(mcf_pkg::ACT_PULL, 3'd7, '0, '0), 1, mcf_pkg::ST_OK, '0});
      rows.push_back('{mk(mcf_pkg::ACT_PUSH, 3'd0, 32'hFFFF_FFFF, 16'd0), 1,
                       mcf_pkg::ST_OK, '0});
      rows.push_back('{mk(mcf_pkg::ACT_OPEN_PROD, '0, '0, '0), 1, mcf_pkg::ST_OK, '0});
      rows.push_back('{mk(mcf_pkg::ACT_OPEN_CONS, 3'd0, '0, '0), 1, mcf_pkg::ST_OK, '0});
      rows.push_back('{mk(mcf_pkg::ACT_OPEN_CONS, 3'd1, '0, '0), 1, mcf_pkg::ST_OK, '0});
      rows.push_back('{mk(mcf_pkg::ACT_PULL, 3'd0, '0, '0), 1, mcf_pkg::ST_OK, '0});
      rows.push_back('{mk(mcf_pkg::ACT_PUSH, '0, 32'hFFFF_FFFF, 16'hFFFF), 1,
                       mcf_pkg::ST_OK, '0});
      rows.push_back('{mk(mcf_pkg::ACT_PUSH, '0, 32'h0000_0000, 16'd1), 1,
                       mcf_pkg::ST_OK, '0});
      rows.push_back('{mk(mcf_pkg::ACT_PULL, 3'd0, '0, '0), 1, mcf_pkg::ST_CHUNK,
                       32'hFFFF_FFFF});
      rows.push_back('{mk(mcf_pkg::ACT_PULL, 3'd1, '0, '0), 1, mcf_pkg::ST_CHUNK,
                       32'hFFFF_FFFF});
      rows.push_back('{mk(mcf_pkg::ACT_CLOSE_CONS, 3'd1, '0, '0), 0, '0, '0});
      rows.push_back('{mk(mcf_pkg::ACT_CLOSE_CONS, 3'd1, '0, '0), 0, '0, '0});
      rows.push_back('{mk(mcf_pkg::ACT_PULL, 3'd1, '0, '0), 1, mcf_pkg::ST_OK, '0});
      rows.push_back('{mk(mcf_pkg::ACT_PULL, 3'd0, '0, '0), 1, mcf_pkg::ST_CHUNK, 32'h0});
      for (int i = 0; i < 17; i++)
         rows.push_back('{mk(mcf_pkg::ACT_PUSH, '0, 32'hA5A5_0000 + i, 16'h5555), 0, '0, '0});
      rows.push_back('{mk(3'd6, 3'd5, 32'h1234_5678, 16'hAAAA), 1, mcf_pkg::ST_OK, '0});
      rows.push_back('{mk(3'd7, 3'd2, '0, '0), 1, mcf_pkg::ST_OK, '0});
      rows.push_back('{mk(mcf_pkg::ACT_CLOSE_PROD, '0, '0, '0), 1, mcf_pkg::ST_OK, '0});
      rows.push_back('{mk(mcf_pkg::ACT_CLOSE_PROD, '0, '0, '0), 1, mcf_pkg::ST_OK, '0});
      rows.push_back('{mk(mcf_pkg::ACT_CLOSE_CONS, 3'd0, '0, '0), 0, '0, '0});
      foreach (rows[i]) begin
         if (rows[i].known) send_directed(rows[i].item, rows[i].st, rows[i].h);
         else send_item(rows[i].item);
      end

      // Phases over settings; the ring fills up and stalls while rsp is held.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin cc = 1; drain_and_write(mcf_pkg::CSR_CHUNK_ROWS, 16'd1); end
            1: begin cc = 8; drain_and_write(mcf_pkg::CSR_CHUNK_ROWS, 16'hFFFF); end
            2: begin cc = 0; drain_and_write(mcf_pkg::CSR_CHUNK_ROWS, 16'd40); end
            3: begin cc = 15; drain_and_write(mcf_pkg::CSR_CHUNK_ROWS, 16'd300); end
            4: begin cc = 3; drain_and_write(mcf_pkg::CSR_CHUNK_ROWS, 16'h8000); end
            default: begin
               cc = $urandom_range(15);
               drain_and_write(mcf_pkg::CSR_CHUNK_ROWS, 16'($urandom()));
            end
         endcase
         drain_and_write(mcf_pkg::CSR_CONSUMER_COUNT,
                         16'(cc) | (16'($urandom()) & 16'hFFF0));
         random_idle = (ph != 2);
         if (ph == 1) begin
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (400) @(negedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         for (int i = 0; i < RANDOM_ITEMS / 8; i++)
            send_item(random_item(($urandom_range(9) == 0) ? 1 : 0));
      end

      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("Checked %0d responses: %0d chunks returned, %0d full rejects, %0d end of stream.",
               n_rsp, n_chunks, n_full, n_eos);
      $display("Covered eight configuration phases with random stalls and a long response hold.");
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
